// File: rtl/core/doa_pkg.sv
package doa_pkg;

	// channel count and per-channel arithmetic limits
	localparam int Chans    = 9;
	localparam int SumW     = 24;
	localparam int OffW     = 16;
	localparam int DeltaW   = 6;
	localparam int ChanW    = 4;
	localparam int SumMax   = 'h7fffff;
	localparam int Step     = 160;
	localparam int DeltaMax = 20;
	localparam int ClipMag  = Step * DeltaMax;

	// reciprocal of the step: q = (m * Recip) >> RecipSh, exact for m < ClipMag
	localparam int RecipSh  = 20;
	localparam int Recip    = (1 << RecipSh) / Step + 1;
	localparam int MagW     = 12;

	// mixer control masks
	localparam logic [15:0] MaskSurround = 16'h0004;
	localparam logic [15:0] MaskAuxA     = 16'h0001;
	localparam logic [15:0] MaskAuxASur  = 16'h0014;
	localparam logic [15:0] MaskAuxB     = 16'h0012;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_FADE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// shared unit outcome for one channel
	typedef struct packed {
		logic signed [SumW-1:0]   new_sum;
		logic signed [DeltaW-1:0] delta;
	} alu_res_t;

endpackage

// File: rtl/core/doa_alu.sv
module doa_alu (
	input  logic                                 fade,
	input  logic signed [doa_pkg::SumW-1:0]      cur,
	input  logic signed [doa_pkg::OffW-1:0]      offset,
	output doa_pkg::alu_res_t                    res
);

	localparam int SumW = doa_pkg::SumW;
	localparam int ProdW = doa_pkg::MagW + 13;

	logic signed [SumW:0]              sum_wide;
	logic signed [SumW-1:0]            sat_sum;
	logic        [doa_pkg::MagW-1:0]   mag;
	logic        [ProdW-1:0]           prod;
	logic        [4:0]                 quot;
	logic signed [doa_pkg::DeltaW-1:0] delta;
	logic signed [SumW:0]              delta_x;
	logic signed [SumW:0]              fade_sum;

	// saturating accumulate of one voice offset
	always_comb begin
		sum_wide = (SumW+1)'(cur) + (SumW+1)'(offset);
		if (sum_wide > (SumW+1)'(doa_pkg::SumMax))
			sat_sum = SumW'(doa_pkg::SumMax);
		else if (sum_wide < -(SumW+1)'(doa_pkg::SumMax))
			sat_sum = -SumW'(doa_pkg::SumMax);
		else
			sat_sum = sum_wide[SumW-1:0];
	end

	// fade delta: -cur/160 toward zero, clipped to twenty steps
	always_comb begin
		mag  = cur[SumW-1] ? doa_pkg::MagW'(-cur) : doa_pkg::MagW'(cur);
		prod = ProdW'(mag) * ProdW'(doa_pkg::Recip);
		quot = prod[doa_pkg::RecipSh +: 5];
		if (cur >= SumW'(doa_pkg::ClipMag))
			delta = -doa_pkg::DeltaW'(doa_pkg::DeltaMax);
		else if (cur <= -SumW'(doa_pkg::ClipMag))
			delta = doa_pkg::DeltaW'(doa_pkg::DeltaMax);
		else if (cur[SumW-1])
			delta = doa_pkg::DeltaW'({1'b0, quot});
		else
			delta = -doa_pkg::DeltaW'({1'b0, quot});
	end

	// move the sum by delta * 160 (128 + 32)
	always_comb begin
		delta_x  = (SumW+1)'(delta);
		fade_sum = (SumW+1)'(cur) + (delta_x <<< 7) + (delta_x <<< 5);
	end

	always_comb begin
		res.delta   = fade ? delta : '0;
		res.new_sum = fade ? fade_sum[SumW-1:0] : sat_sum;
	end

endmodule

// File: rtl/core/doa_store.sv
module doa_store #(
	parameter int DEPTH = 72,
	parameter int AW    = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [AW-1:0]                     rd_addr,
	output logic signed [doa_pkg::SumW-1:0]   rd_sum,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic signed [doa_pkg::SumW-1:0]   wr_sum,
	input  logic                              clr,
	input  logic [AW-1:0]                     clr_base
);

	logic signed [doa_pkg::SumW-1:0] mem [DEPTH];
	logic signed [doa_pkg::SumW-1:0] data_s1;
	logic        [DEPTH-1:0]         valid_q;
	logic        [DEPTH-1:0]         valid_d;
	logic                            vld_s1;

	// sum storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_sum;
		data_s1 <= mem[rd_addr];
	end

	// next valid bits; a clear of a studio wins over a late write
	always_comb begin
		valid_d = valid_q;
		if (wr_en)
			valid_d[wr_addr] = 1'b1;
		if (clr) begin
			for (int i = 0; i < doa_pkg::Chans; i++)
				valid_d[AW'(clr_base + AW'(i))] = 1'b0;
		end
	end

	// per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1  <= valid_q[rd_addr];
			valid_q <= valid_d;
		end
	end

	// an entry never written since reset or clear reads as zero
	assign rd_sum = vld_s1 ? data_s1 : '0;

endmodule

// File: rtl/core/depop_offset_accumulator_top.sv
// Depop offset accumulator: nine saturating offset sums per studio.
//
// Command channel: an item (op, studio, mixer_ctrl, nine offsets) is taken
// at a rising edge where start is high and busy is low.
//   op 0  adds the retired voice offsets into the studio sums (gated by
//         mixer_ctrl); busy for the channel sweep, no results.
//   op 1  fade step; busy for the channel sweep, nine results follow.
//   op 2  clears the studio sums at the accept edge; never busy.
//   op 3, or a studio >= STUDIOS, is taken and ignored.
// Results: strobe marks one result per cycle, channel 0..8, last on the
// ninth. The first result passes the sequencer, the registered sum read
// and the result register after the accept edge. The receiver cannot
// stall, so results are never held. Throughput: a new add or fade item
// waits until busy drops after the last sweep, since the single sum read
// port and the shared add/fade unit handle one channel per cycle.
// Reset: asynchronous, active low; all sums read as zero afterwards (per
// entry valid bits), no clearing pass is needed.
module depop_offset_accumulator_top #(
	parameter int STUDIOS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [2:0]         studio,
	input  logic [15:0]        mixer_ctrl,
	input  logic signed [15:0] off_main_left,
	input  logic signed [15:0] off_main_right,
	input  logic signed [15:0] off_main_surround,
	input  logic signed [15:0] off_auxa_left,
	input  logic signed [15:0] off_auxa_right,
	input  logic signed [15:0] off_auxa_surround,
	input  logic signed [15:0] off_auxb_left,
	input  logic signed [15:0] off_auxb_right,
	input  logic signed [15:0] off_auxb_surround,
	output logic               strobe,
	output logic [3:0]         channel,
	output logic signed [23:0] fade_start,
	output logic signed [5:0]  fade_delta,
	output logic               last
);

	localparam int Chans = doa_pkg::Chans;
	localparam int DEPTH = STUDIOS * Chans;
	localparam int AW    = $clog2(DEPTH);
	localparam int ChW   = doa_pkg::ChanW;

	doa_pkg::state_t                   state_q;
	logic [ChW-1:0]                    rd_q;
	logic                              fade_q;
	logic [AW-1:0]                     base_q;
	logic [Chans-1:0]                  en_q;
	logic signed [doa_pkg::OffW-1:0]   off_q [Chans];

	logic                              v_s1;
	logic [ChW-1:0]                    ch_s1;
	logic [AW-1:0]                     addr_s1;

	logic                              accept;
	logic                              in_range;
	doa_pkg::op_t                      op_in;
	logic [AW-1:0]                     base_in;
	logic [AW-1:0]                     rd_addr;
	logic signed [doa_pkg::SumW-1:0]   cur_sum;
	doa_pkg::alu_res_t                 alu_res;
	logic                              wr_en;

	logic                              strobe_q;
	logic [ChW-1:0]                    channel_q;
	logic signed [doa_pkg::SumW-1:0]   start_q;
	logic signed [doa_pkg::DeltaW-1:0] delta_q;
	logic                              last_q;

	// command decode
	assign accept   = start && !busy;
	assign op_in    = doa_pkg::op_t'(op);
	assign in_range = 32'(studio) < STUDIOS;
	assign base_in  = AW'(32'(studio) * 32'(Chans));
	assign busy     = (state_q == doa_pkg::ST_RUN);

	// sequencer: one channel read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= doa_pkg::ST_IDLE;
			rd_q    <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= busy;
			unique case (state_q)
				doa_pkg::ST_IDLE: begin
					rd_q <= '0;
					if (accept && in_range &&
					    (op_in == doa_pkg::OP_ADD || op_in == doa_pkg::OP_FADE))
						state_q <= doa_pkg::ST_RUN;
				end
				doa_pkg::ST_RUN: begin
					rd_q <= rd_q + ChW'(1);
					if (rd_q == ChW'(Chans - 1))
						state_q <= doa_pkg::ST_IDLE;
				end
				default: state_q <= doa_pkg::ST_IDLE;
			endcase
		end
	end

	// item payload, held for the whole sweep
	always_ff @(posedge clk) begin
		if (accept) begin
			fade_q   <= (op_in == doa_pkg::OP_FADE);
			base_q   <= base_in;
			en_q[0]  <= 1'b1;
			en_q[1]  <= 1'b1;
			en_q[2]  <= |(mixer_ctrl & doa_pkg::MaskSurround);
			en_q[3]  <= |(mixer_ctrl & doa_pkg::MaskAuxA);
			en_q[4]  <= |(mixer_ctrl & doa_pkg::MaskAuxA);
			en_q[5]  <= |(mixer_ctrl & doa_pkg::MaskAuxA) &&
			            |(mixer_ctrl & doa_pkg::MaskAuxASur);
			en_q[6]  <= |(mixer_ctrl & doa_pkg::MaskAuxB);
			en_q[7]  <= |(mixer_ctrl & doa_pkg::MaskAuxB);
			en_q[8]  <= |(mixer_ctrl & doa_pkg::MaskAuxB) &&
			            |(mixer_ctrl & doa_pkg::MaskSurround);
			off_q[0] <= off_main_left;
			off_q[1] <= off_main_right;
			off_q[2] <= off_main_surround;
			off_q[3] <= off_auxa_left;
			off_q[4] <= off_auxa_right;
			off_q[5] <= off_auxa_surround;
			off_q[6] <= off_auxb_left;
			off_q[7] <= off_auxb_right;
			off_q[8] <= off_auxb_surround;
		end
		ch_s1   <= rd_q;
		addr_s1 <= rd_addr;
	end

	assign rd_addr = AW'(base_q + AW'(rd_q));

	doa_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_sum   (cur_sum),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_sum   (alu_res.new_sum),
		.clr      (accept && in_range && op_in == doa_pkg::OP_CLEAR),
		.clr_base (base_in)
	);

	// shared add / fade unit, one channel per cycle
	doa_alu u_alu (
		.fade   (fade_q),
		.cur    (cur_sum),
		.offset (off_q[ch_s1]),
		.res    (alu_res)
	);

	assign wr_en = v_s1 && (fade_q || en_q[ch_s1]);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= v_s1 && fade_q;
	end

	always_ff @(posedge clk) begin
		channel_q <= ch_s1;
		start_q   <= cur_sum;
		delta_q   <= alu_res.delta;
		last_q    <= (ch_s1 == ChW'(Chans - 1));
	end

	assign strobe     = strobe_q;
	assign channel    = channel_q;
	assign fade_start = start_q;
	assign fade_delta = delta_q;
	assign last       = last_q;

endmodule

// File: rtl/core/doa_checker.sv
module doa_checker #(
	parameter int STUDIOS = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         op,
	input logic [2:0]         studio,
	input logic               strobe,
	input logic [3:0]         channel,
	input logic signed [23:0] fade_start,
	input logic signed [5:0]  fade_delta,
	input logic               last
);

	// last is flagged exactly on the ninth channel
	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == (channel == 4'd8)))
		else $error("last does not match final channel");

	// results run as an unbroken burst in channel order
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (channel == 4'($past(channel) + 4'd1)))
		else $error("fade results not contiguous");

	// a fade burst ends cleanly
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result after last");

	// large positive sums use the clipped delta
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (fade_start >= 24'sd3200) |-> fade_delta == -6'sd20)
		else $error("positive clip wrong");

	// a fade command in range has its first result, channel 0, on show
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == 2'd1 && (32'(studio) < STUDIOS)
		|-> ##3 (strobe && channel == 4'd0))
		else $error("fade latency wrong");

endmodule

bind depop_offset_accumulator_top doa_checker #(.STUDIOS(STUDIOS)) u_doa_checker (.*);
